@@ rtl/core/dnle_pkg.sv @@
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 10;
    localparam logic [7:0]  DOT_CHAR   = 8'h2E;
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [9:0]  MAX_LEN_RST = 10'd496;

    typedef struct packed {
        logic [BYTE_W-1:0] char_in;
        logic              is_end;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic [LEN_W-1:0]  name_length;
        logic              truncated;
        logic              label_overflow;
    } result_t;

    // Controls broadcast to every label cell.
    typedef struct packed {
        logic              wr;
        logic              shift;
        logic [BYTE_W-1:0] wr_byte;
    } cell_ctl_t;

endpackage

@@ rtl/core/dnle_cell.sv @@
// ----------------------------------------------------------------------------
// dnle_cell
// One label buffer cell: loads a character when addressed, takes its
// neighbor's byte when the chain drains toward the head.
// ----------------------------------------------------------------------------
module dnle_cell (
    input  logic                          clk,
    input  dnle_pkg::cell_ctl_t           ctl,
    input  logic                          hit,
    input  logic [dnle_pkg::BYTE_W-1:0]   nbr_byte,
    output logic [dnle_pkg::BYTE_W-1:0]   cell_byte
);

    logic [dnle_pkg::BYTE_W-1:0] byte_reg;
    logic [dnle_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.shift)
        begin
            byte_next = nbr_byte;
        end
        else if (ctl.wr && hit)
        begin
            byte_next = ctl.wr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

@@ rtl/core/dns_name_label_encoder.sv @@
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted host name to DNS wire-format labels, built on a chain of byte cells.
// ----------------------------------------------------------------------------
// Characters: accepted one per cycle, no result.
// Dot or end item: accepted, then the length byte and the label bytes draining
//   from the head cell are emitted (unless the label does not fit), then the
//   terminator after an end item; the input stalls meanwhile, and dst_stall holds each byte.
// The length byte is emitted from ST_LEN through the output register.
// Reset (rst_n, async low) clears control and sets max_len to 496; cells and output data unreset.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
    parameter int unsigned LABEL_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  dnle_pkg::item_t      src_data,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output dnle_pkg::result_t    dst_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [9:0]           cfg_data
);

    localparam int unsigned CW = $clog2(LABEL_DEPTH + 1);
    localparam int unsigned SW = dnle_pkg::LEN_W + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_BODY = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [dnle_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic                       stopped_reg, stopped_next;
    logic                       trunc_reg, trunc_next;
    logic                       ovf_reg, ovf_next;
    logic                       end_reg, end_next;
    logic [dnle_pkg::LEN_W-1:0] max_len_reg;

    logic                       out_valid_reg, out_valid_next;
    dnle_pkg::result_t          out_data_reg, out_data_next;

    dnle_pkg::cell_ctl_t        ctl;
    logic [dnle_pkg::BYTE_W-1:0] cell_bytes [LABEL_DEPTH];

    logic accept;
    logic ocan;
    logic fit;
    logic [SW-1:0] need;

    assign accept    = src_valid && !src_stall;
    assign src_stall = (state_reg != ST_IDLE);
    assign ocan      = !out_valid_reg || !dst_stall;
    assign cfg_ready = 1'b1;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

    assign need = SW'(pos_reg) + SW'(count_reg) + SW'(1);
    assign fit  = need < SW'(max_len_reg);

    genvar gi;
    generate
        for (gi = 0; gi < LABEL_DEPTH; gi++)
        begin : g_cell
            logic [dnle_pkg::BYTE_W-1:0] nbr;
            if (gi == LABEL_DEPTH - 1)
            begin : g_tail
                assign nbr = cell_bytes[gi];
            end
            else
            begin : g_mid
                assign nbr = cell_bytes[gi+1];
            end
            dnle_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .hit       (count_reg == CW'(gi)),
                .nbr_byte  (nbr),
                .cell_byte (cell_bytes[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        stopped_next   = stopped_reg;
        trunc_next     = trunc_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && dst_stall;
        out_data_next  = out_data_reg;
        ctl.wr         = 1'b0;
        ctl.shift      = 1'b0;
        ctl.wr_byte    = src_data.char_in;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    end_next = src_data.is_end;
                    if (src_data.is_end || (!stopped_reg &&
                        src_data.char_in == dnle_pkg::DOT_CHAR))
                    begin
                        if (!stopped_reg && (count_reg != '0 || !src_data.is_end))
                        begin
                            count_next = '0;
                            if (fit)
                            begin
                                rem_next   = count_reg;
                                pos_next   = pos_reg + dnle_pkg::LEN_W'(count_reg)
                                             + dnle_pkg::LEN_W'(1);
                                state_next = ST_LEN;
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                                trunc_next   = 1'b1;
                                state_next   = src_data.is_end ? ST_TERM : ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_TERM;
                        end
                    end
                    else if (!stopped_reg)
                    begin
                        if (count_reg == CW'(LABEL_DEPTH))
                        begin
                            ovf_next     = 1'b1;
                            stopped_next = 1'b1;
                            count_next   = '0;
                        end
                        else
                        begin
                            ctl.wr     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            ST_LEN:
            begin
                if (ocan)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.out_byte = dnle_pkg::BYTE_W'(rem_reg);
                    if (rem_reg != '0)
                    begin
                        state_next = ST_BODY;
                    end
                    else
                    begin
                        state_next = end_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_BODY:
            begin
                if (ocan)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.out_byte = cell_bytes[0];
                    ctl.shift = 1'b1;
                    rem_next  = rem_reg - CW'(1);
                    if (rem_reg == CW'(1))
                    begin
                        state_next = end_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                if (ocan)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.out_byte       = dnle_pkg::ZERO_BYTE;
                    out_data_next.out_last       = 1'b1;
                    out_data_next.name_length    = pos_reg + dnle_pkg::LEN_W'(1);
                    out_data_next.truncated      = trunc_reg;
                    out_data_next.label_overflow = ovf_reg;
                    count_next   = '0;
                    pos_next     = '0;
                    stopped_next = 1'b0;
                    trunc_next   = 1'b0;
                    ovf_next     = 1'b0;
                    end_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            pos_reg       <= '0;
            stopped_reg   <= 1'b0;
            trunc_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= dnle_pkg::MAX_LEN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            stopped_reg   <= stopped_next;
            trunc_reg     <= trunc_next;
            ovf_reg       <= ovf_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/core/dnle_checker.sv @@
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks for the DNS name label encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dnle_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  logic                 src_stall,
    input  dnle_pkg::item_t      src_data,
    input  logic                 dst_valid,
    input  logic                 dst_stall,
    input  dnle_pkg::result_t    dst_data
);

    // stalled output beat holds
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
        else $error("stalled output beat changed");

    a_side_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_data.out_last |->
            dst_data.name_length == '0 && !dst_data.truncated
            && !dst_data.label_overflow)
        else $error("status fields set on a non-terminator beat");

    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.out_last |->
            dst_data.out_byte == dnle_pkg::ZERO_BYTE
            && dst_data.name_length != '0)
        else $error("bad terminator beat");

    // an end beat always leads to a terminator phase
    a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall && src_data.is_end |=> src_stall)
        else $error("input not held after end beat");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);

@@ bench/dnle_bench_pkg.sv @@
// ----------------------------------------------------------------------------
// dnle_bench_pkg
// Scoreboard for the DNS name label encoder: tracks label state per accepted
// character beat, queues the wire-format bytes it expects, checks each beat.
// ----------------------------------------------------------------------------
package dnle_bench_pkg;

    import dnle_pkg::*;

    localparam int unsigned LABEL_SLOTS = 32;

    class label_stream_scoreboard;

        logic [LEN_W-1:0]  max_len;
        logic [BYTE_W-1:0] label_bytes [LABEL_SLOTS];
        int unsigned       label_count;
        int unsigned       out_position;
        bit                stopped;
        bit                trunc_seen;
        bit                overflow_seen;
        result_t           expected_bytes [$];
        int unsigned       errors;

        function new();
            max_len = MAX_LEN_RST;
            errors  = 0;
            clear_name();
        endfunction

        function void clear_name();
            label_count   = 0;
            out_position  = 0;
            stopped       = 1'b0;
            trunc_seen    = 1'b0;
            overflow_seen = 1'b0;
        endfunction

        function void set_max_len(logic [LEN_W-1:0] value);
            max_len = value;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function void expect_byte(logic [BYTE_W-1:0] value);
            result_t r;
            r = '0;
            r.out_byte = value;
            expected_bytes.push_back(r);
        endfunction

        // Length byte plus label, or stop with truncation when it does not fit.
        function void flush_label();
            if (out_position + label_count + 1 < int'(max_len))
            begin
                expect_byte(BYTE_W'(label_count));
                for (int i = 0; i < label_count; i++)
                    expect_byte(label_bytes[i]);
                out_position = (out_position + label_count + 1) & 32'h3FF;
            end
            else
            begin
                stopped    = 1'b1;
                trunc_seen = 1'b1;
            end
            label_count = 0;
        endfunction

        // Returns 1 when the beat was not simply dropped by a stopped name.
        function bit take_item(item_t it);
            result_t r;
            if (it.is_end)
            begin
                if (!stopped && label_count > 0)
                    flush_label();
                r = '0;
                r.out_byte       = ZERO_BYTE;
                r.out_last       = 1'b1;
                r.name_length    = LEN_W'(out_position + 1);
                r.truncated      = trunc_seen;
                r.label_overflow = overflow_seen;
                expected_bytes.push_back(r);
                clear_name();
                return 1'b1;
            end
            if (stopped)
                return 1'b0;
            if (it.char_in == DOT_CHAR)
            begin
                flush_label();
                return 1'b1;
            end
            if (label_count >= LABEL_SLOTS)
            begin
                overflow_seen = 1'b1;
                stopped       = 1'b1;
                label_count   = 0;
                return 1'b1;
            end
            label_bytes[label_count] = it.char_in;
            label_count++;
            return 1'b1;
        endfunction

        function void check_byte(result_t got, longint unsigned stamp);
            result_t want;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0d ns: beat with nothing expected, got byte=%h last=%b len=%0d",
                         stamp, got.out_byte, got.out_last, got.name_length);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0d ns: expected byte=%h last=%b len=%0d trunc=%b ovf=%b",
                         stamp, want.out_byte, want.out_last, want.name_length,
                         want.truncated, want.label_overflow);
                $display("%0d ns: actual   byte=%h last=%b len=%0d trunc=%b ovf=%b",
                         stamp, got.out_byte, got.out_last, got.name_length,
                         got.truncated, got.label_overflow);
            end
        endfunction

    endclass

endpackage

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives host names into dns_name_label_encoder one character beat at a time
// under random source gaps and sink stalls, one long sink hold-off, and a
// range of max_len settings; every encoded byte is checked by the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dnle_pkg::*;
    import dnle_bench_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 460;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 60;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_stall;
    item_t             src_data = '0;
    logic              dst_valid;
    logic              dst_stall = 1'b0;
    result_t           dst_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data = '0;

    label_stream_scoreboard sb;
    int unsigned live_items = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;
    int source_quiet = 0;
    int sink_quiet = 0;

    dns_name_label_encoder #(
        .LABEL_DEPTH (LABEL_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random gap per beat, with occasional runs of back-to-back beats.
    function automatic int draw_gap(ref int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 11);
    endfunction

    function automatic item_t char_item(logic [BYTE_W-1:0] c);
        item_t it;
        it.char_in = c;
        it.is_end  = 1'b0;
        return it;
    endfunction

    function automatic item_t end_item(logic [BYTE_W-1:0] c);
        item_t it;
        it.char_in = c;
        it.is_end  = 1'b1;
        return it;
    endfunction

    function automatic void add_name(ref item_t q[$]);
        int labels;
        int len;
        int pick;
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 20))
                q.push_back(($urandom_range(0, 7) == 0)
                            ? end_item(BYTE_W'($urandom_range(0, 255)))
                            : char_item(BYTE_W'($urandom_range(0, 255))));
            q.push_back(end_item(BYTE_W'($urandom_range(0, 255))));
            return;
        end
        if ($urandom_range(0, 9) == 0)
            q.push_back(char_item(DOT_CHAR));
        labels = $urandom_range(1, 5);
        for (int i = 0; i < labels; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 8);
            else if (pick < 85)
                len = $urandom_range(9, 31);
            else if (pick < 93)
                len = LABEL_SLOTS;
            else
                len = $urandom_range(LABEL_SLOTS + 1, LABEL_SLOTS + 4);
            repeat (len)
            begin
                do
                    c = BYTE_W'($urandom_range(0, 255));
                while (c == DOT_CHAR);
                q.push_back(char_item(c));
            end
            if (i < labels - 1 || $urandom_range(0, 4) == 0)
                q.push_back(char_item(DOT_CHAR));
        end
        q.push_back(end_item(BYTE_W'($urandom_range(0, 255))));
    endfunction

    function automatic logic [LEN_W-1:0] pick_max_len(int phase);
        case (phase)
            0: return 10'd2;
            1: return 10'd512;
            2: return 10'd0;
            3: return 10'd1;
            4: return 10'd1023;
            default:
            begin
                case ($urandom_range(0, 3))
                    0, 1: return LEN_W'($urandom_range(2, 64));
                    2: return LEN_W'($urandom_range(2, 512));
                    default: return LEN_W'($urandom_range(0, 1023));
                endcase
            end
        endcase
    endfunction

    // Called right after a rising edge; returns right after the last accept edge.
    task automatic drive_items(input item_t items[$]);
        int gap;
        foreach (items[i])
        begin
            gap = draw_gap(source_quiet);
            if (gap > 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            src_valid <= 1'b1;
            src_data  <= items[i];
            do
                @(posedge clk);
            while (src_stall !== 1'b0);
            void'(sb.take_item(items[i]));
            live_items++;
        end
        src_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_max_len(value);
    endtask

    initial
    begin : sink
        int gap;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (holds_done < holds_asked)
            begin
                gap = HOLD_CYCLES;
                holds_done++;
            end
            else
                gap = draw_gap(sink_quiet);
            if (gap > 0)
            begin
                dst_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                dst_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (dst_valid !== 1'b1);
            sb.check_byte(dst_data, $time);
        end
    end

    initial
    begin : stimulus
        item_t batch [$];
        int unsigned directed_live;
        int phase;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leading dot, zero and 0xFF bytes, double dot, trailing dot, empty
        // name, then a name left open across a max_len change.
        batch = '{char_item(DOT_CHAR), char_item(8'h00), char_item(8'hFF),
                  char_item(DOT_CHAR), char_item(DOT_CHAR), char_item(8'h61),
                  end_item(8'hFF),
                  char_item(8'h71), char_item(DOT_CHAR), end_item(8'h00),
                  end_item(8'h55),
                  char_item(8'h61), char_item(8'h62)};
        drive_items(batch);
        wait_idle();
        write_max_len(10'd3);
        batch = '{char_item(DOT_CHAR), end_item(8'hAA),
                  char_item(8'h78), end_item(8'h00)};
        drive_items(batch);
        wait_idle();
        write_max_len(10'd4);
        batch = '{char_item(8'h41), char_item(8'h42), end_item(8'h00),
                  char_item(8'h41), char_item(8'h42), char_item(8'h43), end_item(8'h00)};
        drive_items(batch);
        wait_idle();
        directed_live = live_items;

        phase = 0;
        while (live_items - directed_live < RANDOM_ITEMS)
        begin
            write_max_len(pick_max_len(phase));
            batch.delete();
            while (batch.size() < PHASE_ITEMS)
                add_name(batch);
            if (phase == 1)
                holds_asked++;
            drive_items(batch);
            wait_idle();
            phase++;
        end

        if (sb.errors == 0)
            $display("dns_name_label_encoder: match");
        else
            $display("dns_name_label_encoder: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("dns_name_label_encoder: mismatch");
        $finish;
    end

endmodule
